### hdl/dihd_pkg.sv
// Shared types and constants of the direct-index dictionary.
package dihd_pkg;

  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam int DEF_ENTRIES  = 1024;
  localparam int DEF_MAX_WALK = 16;

  // Input tdata: key, attribute_value, parent_key, ancestor_key, default_value,
  // use_given_default, then zero fill to whole bytes.
  localparam int IN_FIELDS_W = 5 * KEY_W + 1;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  // Output tdata: result_value, result_flag, status, zero fill.
  localparam int OUT_FIELDS_W = VAL_W + 1 + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_GET       = 3'd1,
    OP_HAS       = 3'd2,
    OP_IS_IN     = 3'd3,
    OP_TO_PARENT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_WALK  = 2'd2
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_VALUE_NULL  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PARENT_NULL = 1'b1;

  // One table entry as it sits in memory.
  typedef struct packed {
    logic             loaded;
    logic [KEY_W-1:0] parent;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### hdl/dihd_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
module dihd_mem #(
  parameter int DEPTH = dihd_pkg::DEF_ENTRIES,
  parameter int WIDTH = dihd_pkg::ENTRY_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/direct_index_dictionary_with_hierarchy.sv
// Top level of the direct-index dictionary with parent hierarchy.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | sink      | in_tvalid/in_tready  | in_tuser operation, in_tdata fields
//  out_    | source    | out_tvalid/out_tready| out_tdata result fields
//  cfg_    | sink      | cfg_wr_en            | cfg_addr register index, cfg_wr_data
//
// Load and unused codes are answered without a memory read; get, has and to_parent
// need one memory read each. An is_in walk follows at most MAX_WALK parent links,
// each read through the single read port that every link goes through.
// After reset a clearing pass writes every entry before the first item is taken;
// configuration writes are taken during it.
// A finished result waits in the output register; the next item is taken as soon
// as that register drains, in the same cycle if out_tready is high.
module direct_index_dictionary_with_hierarchy #(
  parameter int ENTRIES  = dihd_pkg::DEF_ENTRIES,
  parameter int MAX_WALK = dihd_pkg::DEF_MAX_WALK
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // slave side
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // key, attribute_value, parent_key, ancestor_key, default_value,
  // use_given_default, zero fill (lowest bit first)
  input  logic [dihd_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [2:0]                      in_tuser,
  // master side
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result_value, result_flag, status, zero fill (lowest bit first)
  output logic [dihd_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [dihd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dihd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int STEP_W = $clog2(MAX_WALK + 1);
  localparam int KW     = dihd_pkg::KEY_W;
  localparam int VW     = dihd_pkg::VAL_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_WALK
  } state_t;

  // Registers
  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  dihd_pkg::op_t         op_r, op_nxt;
  logic [KW-1:0]         key_r, key_nxt;   // query key, or current node of a walk
  logic [KW-1:0]         anc_r, anc_nxt;
  logic [VW-1:0]         dflt_r, dflt_nxt;
  logic                  ugd_r, ugd_nxt;
  logic                  inrange_r, inrange_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  logic [VW-1:0]         value_null_r, value_null_nxt;
  logic [KW-1:0]         parent_null_r, parent_null_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [VW-1:0]         res_value_r, res_value_nxt;
  logic                  res_flag_r, res_flag_nxt;
  dihd_pkg::status_t     res_status_r, res_status_nxt;

  // Memory port
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  dihd_pkg::entry_t      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  dihd_pkg::entry_t      mem_rdata;

  // Unpacked input fields
  dihd_pkg::op_t         in_op;
  logic [KW-1:0]         in_key;
  logic [VW-1:0]         in_attr;
  logic [KW-1:0]         in_parent;
  logic [KW-1:0]         in_anc;
  logic [VW-1:0]         in_dflt;
  logic                  in_ugd;
  logic                  in_fire;
  logic                  in_key_ok;

  // Walk helpers
  logic [KW-1:0]         next_id;
  logic                  next_running;
  logic                  hit;

  function automatic logic walk_running(input logic [KW-1:0] id,
                                        input logic [KW-1:0] pnull,
                                        input logic [KW-1:0] anc);
    walk_running = (id < KW'(ENTRIES)) && (id != pnull) && (id != anc);
  endfunction

  assign in_op     = dihd_pkg::op_t'(in_tuser);
  assign in_key    = in_tdata[KW-1:0];
  assign in_attr   = in_tdata[KW+VW-1:KW];
  assign in_parent = in_tdata[2*KW+VW-1:KW+VW];
  assign in_anc    = in_tdata[3*KW+VW-1:2*KW+VW];
  assign in_dflt   = in_tdata[3*KW+2*VW-1:3*KW+VW];
  assign in_ugd    = in_tdata[3*KW+2*VW];

  // Take an item only while idle and with room in the output register.
  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign in_key_ok = in_key < KW'(ENTRIES);

  // Follow one parent link; an unloaded node counts as a root.
  assign next_id      = mem_rdata.loaded ? mem_rdata.parent : parent_null_r;
  assign next_running = walk_running(next_id, parent_null_r, anc_r);
  assign hit          = inrange_r && mem_rdata.loaded;

  dihd_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (dihd_pkg::ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    anc_nxt         = anc_r;
    dflt_nxt        = dflt_r;
    ugd_nxt         = ugd_r;
    inrange_nxt     = inrange_r;
    steps_nxt       = steps_r;
    value_null_nxt  = value_null_r;
    parent_null_nxt = parent_null_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    res_value_nxt   = res_value_r;
    res_flag_nxt    = res_flag_r;
    res_status_nxt  = res_status_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_cnt_r;
    mem_wdata       = '0;
    mem_raddr       = in_key[IDX_W-1:0];

    // Configuration writes land in any state.
    if (cfg_wr_en) begin
      case (cfg_addr)
        dihd_pkg::CFG_VALUE_NULL:  value_null_nxt  = cfg_wr_data;
        dihd_pkg::CFG_PARENT_NULL: parent_null_nxt = cfg_wr_data;
        default: ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        // Sweep the table, dropping every loaded bit.
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          key_nxt     = in_key;
          anc_nxt     = in_anc;
          dflt_nxt    = in_dflt;
          ugd_nxt     = in_ugd;
          inrange_nxt = in_key_ok;
          steps_nxt   = '0;
          res_value_nxt  = '0;
          res_flag_nxt   = 1'b0;
          res_status_nxt = dihd_pkg::ST_OK;
          case (in_op)
            dihd_pkg::OP_LOAD: begin
              out_tvalid_nxt = 1'b1;
              if (in_key_ok) begin
                mem_we    = 1'b1;
                mem_waddr = in_key[IDX_W-1:0];
                mem_wdata = '{loaded: 1'b1, parent: in_parent, value: in_attr};
              end else begin
                res_status_nxt = dihd_pkg::ST_RANGE;
              end
            end
            dihd_pkg::OP_GET, dihd_pkg::OP_HAS, dihd_pkg::OP_TO_PARENT: begin
              state_nxt = S_LOOK;
            end
            dihd_pkg::OP_IS_IN: begin
              if (walk_running(in_key, parent_null_r, in_anc)) begin
                state_nxt = S_WALK;
              end else begin
                // Walk ends before the first link.
                out_tvalid_nxt = 1'b1;
                res_flag_nxt   = (in_key != parent_null_r) && (in_key == in_anc);
              end
            end
            default: begin
              out_tvalid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_LOOK: begin
        out_tvalid_nxt = 1'b1;
        state_nxt      = S_IDLE;
        case (op_r)
          dihd_pkg::OP_GET: begin
            if (hit) begin
              res_value_nxt = mem_rdata.value;
            end else begin
              res_value_nxt = ugd_r ? dflt_r : value_null_r;
            end
          end
          dihd_pkg::OP_HAS:       res_flag_nxt  = hit;
          dihd_pkg::OP_TO_PARENT: res_value_nxt = hit ? mem_rdata.parent : parent_null_r;
          default: ;
        endcase
      end

      S_WALK: begin
        if (next_running && (steps_r != STEP_W'(MAX_WALK - 1))) begin
          // Advance to the parent and read its entry.
          key_nxt   = next_id;
          mem_raddr = next_id[IDX_W-1:0];
          steps_nxt = steps_r + 1'b1;
        end else begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
          if (next_running) begin
            res_status_nxt = dihd_pkg::ST_WALK;
          end else begin
            res_flag_nxt = (next_id != parent_null_r) && (next_id == anc_r);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      out_tvalid_r  <= 1'b0;
      value_null_r  <= '0;
      parent_null_r <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      value_null_r  <= value_null_nxt;
      parent_null_r <= parent_null_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    anc_r        <= anc_nxt;
    dflt_r       <= dflt_nxt;
    ugd_r        <= ugd_nxt;
    inrange_r    <= inrange_nxt;
    steps_r      <= steps_nxt;
    res_value_r  <= res_value_nxt;
    res_flag_r   <= res_flag_nxt;
    res_status_r <= res_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(dihd_pkg::OUT_DATA_W - dihd_pkg::OUT_FIELDS_W)'(0),
                       res_status_r, res_flag_r, res_value_r};

  // No item is taken while the clearing pass runs.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("item taken during clearing pass");

  // A lookup or walk only runs with an empty output register.
  a_out_free_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK || state_r == S_WALK) |-> !out_tvalid_r)
    else $error("output register busy while an item is in work");

  // The walk never counts past its limit.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (steps_r < STEP_W'(MAX_WALK)))
    else $error("walk step count out of bounds");

  // Memory writes come only from the clearing pass or a load.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || (in_fire && in_op == dihd_pkg::OP_LOAD)))
    else $error("unexpected table write");

endmodule

### tb/direct_index_dictionary_with_hierarchy_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the direct-index dictionary with parent hierarchy.
module direct_index_dictionary_with_hierarchy_tb;

  localparam int ENTRIES        = dihd_pkg::DEF_ENTRIES;
  localparam int MAX_WALK       = dihd_pkg::DEF_MAX_WALK;
  localparam int KEY_W          = dihd_pkg::KEY_W;
  localparam int VAL_W          = dihd_pkg::VAL_W;
  localparam int IN_DATA_W      = dihd_pkg::IN_DATA_W;
  localparam int IN_FIELDS_W    = dihd_pkg::IN_FIELDS_W;
  localparam int OUT_DATA_W     = dihd_pkg::OUT_DATA_W;
  localparam int OUT_FIELDS_W   = dihd_pkg::OUT_FIELDS_W;
  localparam int CFG_ADDR_W     = dihd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W     = dihd_pkg::CFG_DATA_W;
  localparam int IDX_W          = $clog2(ENTRIES);
  // Most random keys land in a small hot set so that loads link into chains and
  // loops that the walks then follow.
  localparam int HOT_KEYS       = 24;
  localparam int RANDOM_ITEMS   = 800;
  localparam int NULL_PHASES    = 4;
  localparam int SETTLE_CYCLES  = MAX_WALK + 4;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int RX_HOLD_AT     = 500;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [63:0] ALL_ONES      = '1;

  // Input item fields, first field in the lowest bits of in_tdata.
  typedef struct packed {
    logic [IN_DATA_W-IN_FIELDS_W-1:0] fill;
    logic                             use_dflt;
    logic [VAL_W-1:0]                 dflt;
    logic [KEY_W-1:0]                 ancestor;
    logic [KEY_W-1:0]                 parent;
    logic [VAL_W-1:0]                 attr;
    logic [KEY_W-1:0]                 key;
  } query_t;

  // Result item fields, first field in the lowest bits of out_tdata.
  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] fill;
    dihd_pkg::status_t                  status;
    logic                               flag;
    logic [VAL_W-1:0]                   value;
  } answer_t;

  // Shadow table of the dictionary plus the queue of answers still owed.
  class dict_scoreboard;
    bit               loaded [ENTRIES];
    logic [VAL_W-1:0] value_mem [ENTRIES];
    logic [KEY_W-1:0] parent_mem [ENTRIES];
    logic [VAL_W-1:0] value_null;
    logic [KEY_W-1:0] parent_null;
    answer_t          expected_q [$];
    int               mismatches;
    int               checked;
    int               walk_cuts;
    int               range_hits;
    int               found_hits;

    function new();
      value_null  = '0;
      parent_null = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function bit slot_loaded(logic [KEY_W-1:0] k);
      return (k < ENTRIES) && loaded[k[IDX_W-1:0]];
    endfunction

    function bit walk_on(logic [KEY_W-1:0] id, logic [KEY_W-1:0] anc);
      return (id < ENTRIES) && (id != parent_null) && (id != anc);
    endfunction

    // Apply one accepted item to the shadow table and queue its answer.
    function void note_item(logic [2:0] op, query_t q);
      answer_t          a;
      logic [KEY_W-1:0] id;
      int               steps;
      a = '0;
      case (op)
        dihd_pkg::OP_LOAD: begin
          if (q.key < ENTRIES) begin
            value_mem[q.key[IDX_W-1:0]]  = q.attr;
            parent_mem[q.key[IDX_W-1:0]] = q.parent;
            loaded[q.key[IDX_W-1:0]]     = 1'b1;
          end else begin
            a.status = dihd_pkg::ST_RANGE;
            range_hits++;
          end
        end
        dihd_pkg::OP_GET: begin
          if (slot_loaded(q.key)) a.value = value_mem[q.key[IDX_W-1:0]];
          else a.value = q.use_dflt ? q.dflt : value_null;
        end
        dihd_pkg::OP_HAS: a.flag = slot_loaded(q.key);
        dihd_pkg::OP_IS_IN: begin
          // An unloaded slot counts as a root; a key out of range ends the walk.
          id    = q.key;
          steps = 0;
          while (steps < MAX_WALK && walk_on(id, q.ancestor)) begin
            id = loaded[id[IDX_W-1:0]] ? parent_mem[id[IDX_W-1:0]] : parent_null;
            steps++;
          end
          if (walk_on(id, q.ancestor)) begin
            a.status = dihd_pkg::ST_WALK;
            walk_cuts++;
          end else begin
            a.flag = (id != parent_null) && (id == q.ancestor);
            if (a.flag) found_hits++;
          end
        end
        dihd_pkg::OP_TO_PARENT: begin
          a.value = slot_loaded(q.key) ? parent_mem[q.key[IDX_W-1:0]] : parent_null;
        end
        default: ;
      endcase
      expected_q.insert(expected_q.size(), a);
    endfunction

    // Compare one result item against the oldest owed answer.
    function void check_result(logic [OUT_DATA_W-1:0] raw);
      answer_t got;
      answer_t want;
      got = raw;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none expected: value %h flag %b status %0d",
                   $time, got.value, got.flag, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value || got.flag !== want.flag ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: result %0d: value exp %h got %h, flag exp %b got %b, ",
                    "status exp %0d got %0d"},
                   $time, checked, want.value, got.value, want.flag, got.flag,
                   want.status, got.status);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // key, attribute_value, parent_key, ancestor_key, default_value,
  // use_given_default, zero fill (lowest bit first)
  logic [IN_DATA_W-1:0]  in_tdata;
  // operation
  logic [2:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // result_value, result_flag, status, zero fill (lowest bit first)
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  dict_scoreboard sb;
  int             items_sent   = 0;
  int             results_seen = 0;
  bit             tx_idle_on   = 1'b1;
  bit             rx_idle_on   = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  direct_index_dictionary_with_hierarchy #(
    .ENTRIES  (ENTRIES),
    .MAX_WALK (MAX_WALK)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  // Draw a key: mostly hot keys, then anywhere in the table, the current root
  // marker, wide random keys and the edges of the key range.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return KEY_W'($urandom_range(HOT_KEYS - 1, 0));
    if (r < 70) return KEY_W'($urandom_range(ENTRIES - 1, 0));
    if (r < 78) return sb.parent_null;
    if (r < 92) return {$urandom, $urandom};
    if (r < 95) return KEY_W'(ENTRIES - 1);
    if (r < 98) return KEY_W'(ENTRIES);
    return ALL_ONES;
  endfunction

  function automatic query_t make_query(logic [KEY_W-1:0] key, logic [VAL_W-1:0] attr = '0,
                                        logic [KEY_W-1:0] parent = '0,
                                        logic [KEY_W-1:0] ancestor = '0,
                                        logic [VAL_W-1:0] dflt = '0, logic use_dflt = 1'b0);
    query_t q;
    q          = '0;
    q.key      = key;
    q.attr     = attr;
    q.parent   = parent;
    q.ancestor = ancestor;
    q.dflt     = dflt;
    q.use_dflt = use_dflt;
    return q;
  endfunction

  // Offer one item after a random gap, hold it until the handshake, then log it.
  // Valid stays high across back-to-back items.
  task automatic send_item(input logic [2:0] op, input query_t q);
    int gap;
    if (items_sent % 40 == 0) tx_idle_on = ($urandom_range(3, 0) != 0);
    gap = tx_idle_on ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= q;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(op, q);
    items_sent++;
  endtask

  // Drop valid and wait until every owed answer is back, then let the block settle.
  task automatic drain_results();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both null registers back to back; only call with the block idle.
  task automatic set_nulls(input logic [63:0] vnull, input logic [63:0] pnull);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= dihd_pkg::CFG_VALUE_NULL;
    cfg_wr_data <= vnull;
    @(posedge clk);
    cfg_addr    <= dihd_pkg::CFG_PARENT_NULL;
    cfg_wr_data <= pnull;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.value_null  = vnull;
    sb.parent_null = pnull;
  endtask

  task automatic send_random_item();
    query_t     q;
    logic [2:0] op;
    int         r;
    r = $urandom_range(99, 0);
    if (r < 30) op = dihd_pkg::OP_LOAD;
    else if (r < 50) op = dihd_pkg::OP_GET;
    else if (r < 62) op = dihd_pkg::OP_HAS;
    else if (r < 82) op = dihd_pkg::OP_IS_IN;
    else if (r < 95) op = dihd_pkg::OP_TO_PARENT;
    else op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    q = make_query(pick_key(), {$urandom, $urandom}, pick_key(), pick_key(),
                   {$urandom, $urandom}, 1'($urandom_range(1, 0)));
    send_item(op, q);
  endtask

  // Load a run of consecutive keys each linked to the next, ending at the root
  // marker or looping back to the first, then walk and query it.
  task automatic send_chain();
    query_t     q;
    logic [2:0] op;
    int         len;
    int         base;
    len  = $urandom_range(20, 2);
    base = $urandom_range(ENTRIES - len, HOT_KEYS);
    for (int i = 0; i < len; i++) begin
      q = make_query(KEY_W'(base + i), {$urandom, $urandom}, KEY_W'(base + i + 1),
                     pick_key(), {$urandom, $urandom}, 1'($urandom_range(1, 0)));
      if (i == len - 1)
        q.parent = ($urandom_range(3, 0) == 0) ? KEY_W'(base) : sb.parent_null;
      send_item(dihd_pkg::OP_LOAD, q);
    end
    repeat (len) begin
      q.key      = KEY_W'(base + $urandom_range(len - 1, 0));
      q.ancestor = ($urandom_range(3, 0) == 0) ? pick_key()
                                               : KEY_W'(base + $urandom_range(len - 1, 0));
      case ($urandom_range(5, 0))
        0:       op = dihd_pkg::OP_TO_PARENT;
        1:       op = dihd_pkg::OP_GET;
        default: op = dihd_pkg::OP_IS_IN;
      endcase
      send_item(op, q);
    end
  endtask

  // Directed opening under the reset nulls (both zero, so key 0 is the root).
  task automatic run_directed();
    // misses: null value, given default, clear loaded bit, root parent
    send_item(dihd_pkg::OP_GET, make_query(KEY_W'(5)));
    send_item(dihd_pkg::OP_GET, make_query(KEY_W'(5), '0, '0, '0, ALL_ONES, 1'b1));
    send_item(dihd_pkg::OP_HAS, make_query(KEY_W'(5)));
    send_item(dihd_pkg::OP_TO_PARENT, make_query(KEY_W'(5)));
    // loads out of range write nothing
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(ENTRIES), ALL_ONES, ALL_ONES));
    send_item(dihd_pkg::OP_LOAD, make_query(ALL_ONES, ALL_ONES, ALL_ONES));
    // first and last slot with extreme contents
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(0), ALL_ONES, ALL_ONES));
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(ENTRIES - 1), '0, '0));
    send_item(dihd_pkg::OP_GET, make_query(KEY_W'(0)));
    send_item(dihd_pkg::OP_GET,
              make_query(KEY_W'(ENTRIES - 1), '0, '0, '0, ALL_ONES, 1'b1));
    send_item(dihd_pkg::OP_HAS, make_query(KEY_W'(ENTRIES - 1)));
    send_item(dihd_pkg::OP_HAS, make_query(KEY_W'(ENTRIES)));
    send_item(dihd_pkg::OP_TO_PARENT, make_query(KEY_W'(0)));
    // query key out of range falls back to the given default
    send_item(dihd_pkg::OP_GET,
              make_query(ALL_ONES, '0, '0, '0, 64'h5555_aaaa_5555_aaaa, 1'b1));
    // two-slot loop: the walk gets cut off, but a direct ancestor is found
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(2), 64'd22, KEY_W'(3)));
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(3), 64'd33, KEY_W'(2)));
    send_item(dihd_pkg::OP_IS_IN, make_query(KEY_W'(2), '0, '0, KEY_W'(7)));
    send_item(dihd_pkg::OP_IS_IN, make_query(KEY_W'(3), '0, '0, KEY_W'(2)));
    // parent out of range ends the walk and still matches the ancestor
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(4), 64'd44, KEY_W'(2000)));
    send_item(dihd_pkg::OP_IS_IN, make_query(KEY_W'(4), '0, '0, KEY_W'(2000)));
    send_item(dihd_pkg::OP_IS_IN, make_query(KEY_W'(4), '0, '0, KEY_W'(9)));
    // unloaded slot on the path ends the walk as a root
    send_item(dihd_pkg::OP_LOAD, make_query(KEY_W'(6), 64'd66, KEY_W'(8)));
    send_item(dihd_pkg::OP_IS_IN, make_query(KEY_W'(6), '0, '0, KEY_W'(1)));
    // ancestor equal to the root marker is never found
    send_item(dihd_pkg::OP_IS_IN, make_query(KEY_W'(ENTRIES - 1), '0, '0, KEY_W'(0)));
    // unused codes change nothing
    send_item(OP_SPARE_FIRST, make_query(KEY_W'(2), ALL_ONES, ALL_ONES, ALL_ONES));
    send_item(OP_SPARE_LAST, make_query(KEY_W'(3), ALL_ONES, ALL_ONES, ALL_ONES));
  endtask

  // Result side: random stalls, no-stall stretches, and one long hold-off that
  // backs the block up while the sender keeps offering items.
  initial begin
    int gap;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (results_seen % 40 == 0) rx_idle_on = ($urandom_range(3, 0) != 0);
      gap = rx_idle_on ? $urandom_range(7, 0) : 0;
      if (results_seen == RX_HOLD_AT) gap = RX_HOLD_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata);
      results_seen++;
    end
  end

  // Stimulus: reset, directed opening, then random phases under different nulls.
  initial begin
    int phase_target;
    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= '0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_addr    <= '0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // The clearing pass takes register writes, so program the first setting now.
    set_nulls('0, '0);
    run_directed();

    for (int phase = 0; phase < NULL_PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1:       set_nulls(ALL_ONES, ALL_ONES);
          2:       set_nulls({$urandom, $urandom}, KEY_W'($urandom_range(HOT_KEYS - 1, 0)));
          default: set_nulls({$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
      phase_target = items_sent + RANDOM_ITEMS / NULL_PHASES;
      while (items_sent < phase_target) begin
        // Halfway through the second phase, hold off until the block is empty.
        if (phase == 1 && items_sent >= phase_target - RANDOM_ITEMS / (2 * NULL_PHASES)
            && items_sent < phase_target - RANDOM_ITEMS / (2 * NULL_PHASES) + 1)
          drain_results();
        if ($urandom_range(11, 0) == 0) send_chain();
        else send_random_item();
      end
    end

    drain_results();
    if (sb.expected_q.size() != 0) begin
      $display("%0d results never arrived", sb.expected_q.size());
      sb.mismatches += sb.expected_q.size();
    end
    $display("covered %0d items and %0d results under %0d null settings", items_sent,
             sb.checked, NULL_PHASES);
    $display("walks cut off %0d, ancestors found %0d, loads out of range %0d",
             sb.walk_cuts, sb.found_hits, sb.range_hits);
    if (sb.mismatches == 0) begin
      $display("direct_index_dictionary_with_hierarchy_tb: done, clean");
    end else begin
      $display("direct_index_dictionary_with_hierarchy_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing pass included.
  initial begin
    #2_000_000;
    $display("direct_index_dictionary_with_hierarchy_tb: done, errors");
    $finish;
  end

endmodule
